### rtl/wcd_pkg.sv
// Package: shared types, constants and log tables for the window class diversity block.
`timescale 1ns / 1ps
package wcd_pkg;
	localparam int MAX_WINDOW_CELLS = 32;
	localparam int FRAC_BITS = 12;
	localparam int CNT_W = $clog2(MAX_WINDOW_CELLS + 1);
	localparam int IDX_W = $clog2(MAX_WINDOW_CELLS);
	localparam int ACC_W = 40;
	localparam logic [63:0] LN2_Q32 = 64'd2977044472;

	typedef struct packed {
		logic [31:0] center_value;
		logic        center_nodata;
		logic [31:0] cell_value;
		logic        cell_in_grid;
		logic        last_cell;
	} wcd_in_t;

	typedef struct packed {
		logic        result_valid;
		logic [5:0]  class_count;
		logic [5:0]  cell_count;
		logic [5:0]  unlike_center_count;
		logic [15:0] diversity;
		logic [15:0] dominance;
		logic [12:0] fragmentation;
		logic [11:0] relative_richness;
	} wcd_out_t;

	typedef struct packed {
		logic             used;
		logic [CNT_W-1:0] count;
		logic [31:0]      code;
	} wcd_link_t;

	typedef logic [MAX_WINDOW_CELLS:0][ACC_W-1:0] wcd_tab_t;

	function automatic logic [ACC_W-1:0] ln_q32(input int unsigned k);
		int unsigned e;
		logic [63:0] m;
		logic [63:0] frac;
		logic [63:0] res;
		e = 0;
		frac = '0;
		res = '0;
		if (k > 1) begin
			for (int i = 1; i < 32; i++) begin
				if ((k >> i) != 0) e = i;
			end
			m = (64'(k) << 30) >> e;
			for (int i = 0; i < 32; i++) begin
				m = (m * m) >> 30;
				frac = frac << 1;
				if (m >= (64'd2 << 30)) begin
					m = m >> 1;
					frac = frac | 64'd1;
				end
			end
			res = 64'(e) * LN2_Q32 + ((frac * LN2_Q32 + (64'd1 << 31)) >> 32);
		end
		return res[ACC_W-1:0];
	endfunction

	function automatic wcd_tab_t build_ln();
		wcd_tab_t t;
		for (int c = 0; c <= MAX_WINDOW_CELLS; c++) t[c] = ln_q32(c);
		return t;
	endfunction

	function automatic wcd_tab_t build_cl();
		wcd_tab_t t;
		logic [63:0] p;
		for (int c = 0; c <= MAX_WINDOW_CELLS; c++) begin
			p = 64'(c) * 64'(ln_q32(c));
			t[c] = p[ACC_W-1:0];
		end
		return t;
	endfunction

	localparam wcd_tab_t LN_TAB = build_ln();
	localparam wcd_tab_t CL_TAB = build_cl();
endpackage

### rtl/wcd_cell.sv
// One class cell: holds a class code and its count, matches broadcast cells, shifts on drain.
`timescale 1ns / 1ps
module wcd_cell import wcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd,
	input  logic [31:0] value,
	input  logic        any_hit,
	input  logic        prev_used,
	input  logic        shift,
	input  wcd_link_t   nxt,
	output wcd_link_t   cur,
	output logic        hit
);
	logic             used_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      code_q;

	assign hit = used_q && (code_q == value);
	assign cur = '{used: used_q, count: count_q, code: code_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			count_q <= '0;
		end else if (shift) begin
			used_q  <= nxt.used;
			count_q <= nxt.count;
		end else if (upd) begin
			if (hit) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!any_hit && !used_q && prev_used) begin
				used_q  <= 1'b1;
				count_q <= CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			code_q <= nxt.code;
		end else if (upd && !any_hit && !used_q && prev_used) begin
			code_q <= value;
		end
	end
endmodule

### rtl/wcd_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wcd_div import wcd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ACC_W-1:0] dividend,
	input  logic [15:0]      divisor,
	output logic [ACC_W-1:0] quotient,
	output logic             done
);
	localparam int STEP_W = $clog2(ACC_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [15:0]       rem_q;
	logic [15:0]       dvs_q;
	logic [ACC_W-1:0]  quo_q;
	logic [16:0]       trial;
	logic              fits;
	logic [16:0]       diff;

	assign trial = {rem_q, quo_q[ACC_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};
	assign quotient = quo_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[ACC_W-2:0], fits};
		end
	end
endmodule

### rtl/window_class_diversity.sv
// Top level: class cell chain, drain accumulator, shared divider and result register.
// One beat per window cell is taken while the block is idle; a beat flagged last_cell starts
// the closing pass: the class chain is shifted out through the entropy accumulator, then
// three runs of the serial divider (entropy mean, fragmentation, relative richness), then the
// result register is loaded once it is free. The next window is taken once the closing pass
// has handed its result to the output register.
`timescale 1ns / 1ps
module window_class_diversity import wcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  wcd_in_t     in_item,
	output logic        res_valid,
	input  logic        res_ready,
	output wcd_out_t    res_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DRAIN = 3'd1;
	localparam logic [2:0] S_DIVS  = 3'd2;
	localparam logic [2:0] S_DIVF  = 3'd3;
	localparam logic [2:0] S_DIVR  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;
	localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (31 - FRAC_BITS);

	logic [2:0]             state_q;
	logic [15:0]            max_q;
	logic [CNT_W-1:0]       n_q, k_q, unlike_q;
	logic                   nodata_q;
	logic [IDX_W-1:0]       drain_q;
	logic [ACC_W-1:0]       acc_q, s_q, h_q, frag_q, rich_q;
	logic                   start_q;
	logic                   out_valid_q;
	wcd_out_t               out_q;

	wcd_link_t              link [MAX_WINDOW_CELLS];
	wcd_link_t              nxt  [MAX_WINDOW_CELLS];
	logic [MAX_WINDOW_CELLS-1:0] hits, used_vec;
	logic                   any_hit, accept, upd, shift;
	logic [ACC_W-1:0]       dvd, quo;
	logic [15:0]            dvs;
	logic                   div_done;
	logic [ACC_W-1:0]       ln_n, ln_k, rnd_div, rnd_dom;
	wcd_out_t               res_next;

	assign in_ready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign upd       = accept && in_item.cell_in_grid && (n_q < CNT_W'(MAX_WINDOW_CELLS));
	assign shift     = state_q == S_DRAIN;
	assign any_hit   = |hits;

	for (genvar i = 0; i < MAX_WINDOW_CELLS; i++) begin : g_cell
		if (i == MAX_WINDOW_CELLS - 1) begin : g_end
			assign nxt[i] = '0;
		end else begin : g_mid
			assign nxt[i] = link[i+1];
		end
		assign used_vec[i] = link[i].used;
		wcd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.upd      (upd),
			.value    (in_item.cell_value),
			.any_hit  (any_hit),
			.prev_used((i == 0) ? 1'b1 : used_vec[(i == 0) ? 0 : i-1]),
			.shift    (shift),
			.nxt      (nxt[i]),
			.cur      (link[i]),
			.hit      (hits[i])
		);
	end

	always_comb begin
		unique case (state_q)
			S_DIVS: begin
				dvd = acc_q;
				dvs = 16'(n_q);
			end
			S_DIVF: begin
				dvd = ACC_W'(k_q) << FRAC_BITS;
				dvs = 16'(n_q);
			end
			S_DIVR: begin
				dvd = (ACC_W'(k_q) << 6) + (ACC_W'(k_q) << 5) + (ACC_W'(k_q) << 2);
				dvs = max_q;
			end
			default: begin
				dvd = '0;
				dvs = 16'd1;
			end
		endcase
	end

	wcd_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.dividend(dvd),
		.divisor (dvs),
		.quotient(quo),
		.done    (div_done)
	);

	assign ln_n = LN_TAB[n_q];
	assign ln_k = LN_TAB[k_q];
	assign rnd_div = (h_q + RND) >> (32 - FRAC_BITS);
	assign rnd_dom = ((ln_k > h_q) ? (ln_k - h_q + RND) : '0) >> (32 - FRAC_BITS);

	always_comb begin
		res_next = '0;
		if (!nodata_q) begin
			res_next.result_valid        = 1'b1;
			res_next.class_count         = 6'(k_q);
			res_next.cell_count          = 6'(n_q);
			res_next.unlike_center_count = 6'(unlike_q);
			if (n_q != '0) begin
				res_next.diversity     = (rnd_div > ACC_W'(16'hFFFF)) ? 16'hFFFF : rnd_div[15:0];
				res_next.dominance     = (rnd_dom > ACC_W'(16'hFFFF)) ? 16'hFFFF : rnd_dom[15:0];
				res_next.fragmentation = (frag_q > ACC_W'(13'h1FFF)) ? 13'h1FFF : frag_q[12:0];
			end
			if (max_q != '0) begin
				res_next.relative_richness = (rich_q > ACC_W'(12'hFFF)) ? 12'hFFF : rich_q[11:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			max_q       <= 16'd10;
			n_q         <= '0;
			k_q         <= '0;
			unlike_q    <= '0;
			nodata_q    <= 1'b0;
			drain_q     <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (cfg_valid && cfg_ready) max_q <= cfg_data;
			if (res_valid && res_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (upd) begin
						n_q <= n_q + CNT_W'(1);
						if (in_item.cell_value != in_item.center_value)
							unlike_q <= unlike_q + CNT_W'(1);
						if (!any_hit) k_q <= k_q + CNT_W'(1);
					end
					if (accept && in_item.last_cell) begin
						nodata_q <= in_item.center_nodata;
						drain_q  <= '0;
						state_q  <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					drain_q <= drain_q + IDX_W'(1);
					if (drain_q == IDX_W'(MAX_WINDOW_CELLS - 1)) begin
						state_q <= S_DIVS;
						start_q <= 1'b1;
					end
				end
				S_DIVS: begin
					if (div_done) begin
						state_q <= S_DIVF;
						start_q <= 1'b1;
					end
				end
				S_DIVF: begin
					if (div_done) begin
						state_q <= S_DIVR;
						start_q <= 1'b1;
					end
				end
				S_DIVR: begin
					if (div_done) state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || res_ready) begin
						out_valid_q <= 1'b1;
						n_q         <= '0;
						k_q         <= '0;
						unlike_q    <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) acc_q <= '0;
		else if (state_q == S_DRAIN) acc_q <= acc_q + CL_TAB[link[0].count];
		if (state_q == S_DIVS && div_done) s_q <= quo;
		if (state_q == S_DIVF) h_q <= (ln_n > s_q) ? (ln_n - s_q) : '0;
		if (state_q == S_DIVF && div_done) frag_q <= quo;
		if (state_q == S_DIVR && div_done) rich_q <= quo;
		if (state_q == S_FIN && (!out_valid_q || res_ready)) out_q <= res_next;
	end

	assign res_valid = out_valid_q;
	assign res_item  = out_q;

	a_k_le_n: assert property (@(posedge clk) disable iff (!arst_n) k_q <= n_q)
		else $error("class count above cell count");
	a_unlike_le_n: assert property (@(posedge clk) disable iff (!arst_n) unlike_q <= n_q)
		else $error("unlike count above cell count");
	a_used_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> $countones(used_vec) == int'(k_q))
		else $error("used cells disagree with class count");
	a_drain_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVS && $past(state_q) == S_DRAIN) |-> used_vec == '0)
		else $error("cell chain not empty after drain");
endmodule
